// ----- hw/rtl/prlp_pkg.sv -----
// Package for the page range list parser: page width, limits, status codes
// and the item structures of the input and result channels.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package prlp_pkg;

	localparam int unsigned PAGE_W   = 13;
	localparam int unsigned CH_W     = 8;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned MAX_PAGE = 4351;
	localparam int unsigned SUM_W    = PAGE_W + 4;

	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_MISSING  = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_UNORDER  = 3'd3,
		ST_FLIPPED  = 3'd4,
		ST_INVALID  = 3'd5
	} status_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            terminator;
	} item_t;

	typedef struct packed {
		logic              range_valid;
		logic [PAGE_W-1:0] range_low;
		logic [PAGE_W-1:0] range_high;
		logic              finished;
		status_t           status;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/prlp_in_if.sv -----
// Input channel of the page range list parser: one character or terminator
// per item, with a valid/ready handshake. Depends on prlp_pkg.
`default_nettype none

interface prlp_in_if;
	logic                       valid;
	logic                       ready;
	logic [prlp_pkg::CH_W-1:0]  ch;
	logic                       terminator;

	modport source (output valid, output ch, output terminator, input ready);
	modport sink (input valid, input ch, input terminator, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/prlp_out_if.sv -----
// Result channel of the page range list parser: a completed range and/or the
// final status per item, with a valid/ready handshake. Depends on prlp_pkg.
`default_nettype none

interface prlp_out_if;
	logic                          valid;
	logic                          ready;
	logic                          range_valid;
	logic [prlp_pkg::PAGE_W-1:0]   range_low;
	logic [prlp_pkg::PAGE_W-1:0]   range_high;
	logic                          finished;
	logic [prlp_pkg::STATUS_W-1:0] status;

	modport source (output valid, output range_valid, output range_low, output range_high,
		output finished, output status, input ready);
	modport sink (input valid, input range_valid, input range_low, input range_high,
		input finished, input status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/prlp_in_stage.sv -----
// Input register of the page range list parser. It holds one accepted item
// until the parser core steps on it. Depends on prlp_pkg and prlp_in_if.
`default_nettype none

module prlp_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	prlp_in_if.sink              items,
	input  wire logic            adv,
	output logic                 valid_s1,
	output prlp_pkg::item_t      item_s1
);

	assign items.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1.ch         <= items.ch;
			item_s1.terminator <= items.terminator;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/prlp_core.sv -----
// Parser core: the phase state machine, the decimal accumulator and the range
// checks, stepping once on each item it is given. Depends on prlp_pkg.
`default_nettype none

module prlp_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire prlp_pkg::item_t item,
	output logic                 has_res,
	output prlp_pkg::result_t    res
);

	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_FIRST  = 5'b00010,
		PH_DASH   = 5'b00100,
		PH_SECOND = 5'b01000,
		PH_AFTER  = 5'b10000
	} phase_t;

	phase_t                      phase_q, phase_d;
	logic [prlp_pkg::PAGE_W-1:0] acc_q, acc_d;
	logic [prlp_pkg::PAGE_W-1:0] first_q, first_d;
	logic [prlp_pkg::PAGE_W-1:0] prev_max_q, prev_max_d;
	logic                        prev_valid_q, prev_valid_d;
	logic                        error_q, error_d;

	logic                        is_digit;
	logic                        is_blank;
	logic [prlp_pkg::SUM_W-1:0]  base;
	logic [prlp_pkg::SUM_W-1:0]  sum;
	logic                        ovf;
	logic                        unord;
	logic                        closed;
	logic                        rv;
	logic                        fin;
	logic [prlp_pkg::PAGE_W-1:0] lo;
	logic [prlp_pkg::PAGE_W-1:0] hi;
	prlp_pkg::status_t           st;

	always_comb begin
		is_digit = item.ch inside {[prlp_pkg::CH_ZERO:prlp_pkg::CH_NINE]};
		is_blank = item.ch inside {prlp_pkg::CH_SPACE, prlp_pkg::CH_TAB,
			prlp_pkg::CH_LF, prlp_pkg::CH_CR};
		base = (phase_q == PH_FIRST || phase_q == PH_SECOND) ?
			{4'b0000, acc_q} : '0;
		sum = (base << 3) + (base << 1) +
			{{(prlp_pkg::SUM_W-4){1'b0}}, item.ch[3:0]};
		ovf = sum > prlp_pkg::SUM_W'(prlp_pkg::MAX_PAGE);
		unord = prev_valid_q && (prev_max_q >= acc_q);
	end

	always_comb begin
		phase_d      = phase_q;
		acc_d        = acc_q;
		first_d      = first_q;
		prev_max_d   = prev_max_q;
		prev_valid_d = prev_valid_q;
		error_d      = error_q;
		rv           = 1'b0;
		fin          = 1'b0;
		lo           = '0;
		hi           = '0;
		st           = prlp_pkg::ST_OK;
		closed       = 1'b0;

		if (error_q) begin
			if (item.terminator) begin
				phase_d      = PH_START;
				acc_d        = '0;
				first_d      = '0;
				prev_valid_d = 1'b0;
				error_d      = 1'b0;
			end
		end else if (item.terminator) begin
			fin = 1'b1;
			case (phase_q)
				PH_FIRST: begin
					if (unord) begin
						st = prlp_pkg::ST_UNORDER;
					end else begin
						rv = 1'b1;
						lo = acc_q;
						hi = acc_q;
					end
				end
				PH_DASH: begin
					st = prlp_pkg::ST_MISSING;
				end
				PH_SECOND: begin
					if (first_q > acc_q) begin
						st = prlp_pkg::ST_FLIPPED;
					end else begin
						rv = 1'b1;
						lo = first_q;
						hi = acc_q;
					end
				end
				default: begin
				end
			endcase
			phase_d      = PH_START;
			acc_d        = '0;
			first_d      = '0;
			prev_valid_d = 1'b0;
			error_d      = 1'b0;
		end else begin
			case (phase_q)
				PH_START, PH_DASH: begin
					if (is_digit) begin
						acc_d = '0;
						if (ovf) begin
							fin = 1'b1;
							st  = prlp_pkg::ST_OVERFLOW;
						end else begin
							acc_d   = sum[prlp_pkg::PAGE_W-1:0];
							phase_d = (phase_q == PH_START) ? PH_FIRST : PH_SECOND;
						end
					end else if (phase_q == PH_DASH || !is_blank) begin
						fin = 1'b1;
						st  = prlp_pkg::ST_MISSING;
					end
				end
				PH_FIRST: begin
					if (is_digit) begin
						if (ovf) begin
							fin = 1'b1;
							st  = prlp_pkg::ST_OVERFLOW;
						end else begin
							acc_d = sum[prlp_pkg::PAGE_W-1:0];
						end
					end else if (unord) begin
						fin = 1'b1;
						st  = prlp_pkg::ST_UNORDER;
					end else if (item.ch == prlp_pkg::CH_DASH) begin
						first_d = acc_q;
						phase_d = PH_DASH;
					end else begin
						rv     = 1'b1;
						lo     = acc_q;
						hi     = acc_q;
						closed = 1'b1;
					end
				end
				PH_SECOND: begin
					if (is_digit) begin
						if (ovf) begin
							fin = 1'b1;
							st  = prlp_pkg::ST_OVERFLOW;
						end else begin
							acc_d = sum[prlp_pkg::PAGE_W-1:0];
						end
					end else if (first_q > acc_q) begin
						fin = 1'b1;
						st  = prlp_pkg::ST_FLIPPED;
					end else begin
						rv     = 1'b1;
						lo     = first_q;
						hi     = acc_q;
						closed = 1'b1;
					end
				end
				default: begin
					if (item.ch == prlp_pkg::CH_COMMA) begin
						phase_d = PH_START;
					end else if (!is_blank) begin
						fin = 1'b1;
						st  = prlp_pkg::ST_INVALID;
					end
				end
			endcase
			if (closed) begin
				prev_max_d   = hi;
				prev_valid_d = 1'b1;
				if (item.ch == prlp_pkg::CH_COMMA) begin
					phase_d = PH_START;
				end else if (is_blank) begin
					phase_d = PH_AFTER;
				end else begin
					fin = 1'b1;
					st  = prlp_pkg::ST_INVALID;
				end
			end
			if (fin) begin
				error_d = 1'b1;
			end
		end
	end

	assign has_res         = rv || fin;
	assign res.range_valid = rv;
	assign res.range_low   = lo;
	assign res.range_high  = hi;
	assign res.finished    = fin;
	assign res.status      = st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			acc_q        <= '0;
			first_q      <= '0;
			prev_max_q   <= '0;
			prev_valid_q <= 1'b0;
			error_q      <= 1'b0;
		end else if (en) begin
			phase_q      <= phase_d;
			acc_q        <= acc_d;
			first_q      <= first_d;
			prev_max_q   <= prev_max_d;
			prev_valid_q <= prev_valid_d;
			error_q      <= error_d;
		end
	end

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		en && error_q && !item.terminator |-> !has_res)
		else $error("Result produced after an error was reported.");

	a_fin_sets_err: assert property (@(posedge clk) disable iff (!arst_n)
		en && fin && !item.terminator |=> error_q)
		else $error("Error not latched after a final status.");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.terminator |=> phase_q == PH_START && !error_q && !prev_valid_q)
		else $error("Terminator did not return the parser to its reset state.");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		en && rv |-> lo <= hi && (!prev_valid_q || prev_max_q < lo))
		else $error("Emitted range is out of order.");

	a_nonfin_ok: assert property (@(posedge clk) disable iff (!arst_n)
		en && rv && !fin |=> !error_q && prev_valid_q && prev_max_q == $past(hi))
		else $error("Range completion did not update the previous maximum.");

endmodule

`default_nettype wire

// ----- hw/rtl/prlp_out_stage.sv -----
// Result register of the page range list parser. It holds one result item
// until the sink takes it. Depends on prlp_pkg and prlp_out_if.
`default_nettype none

module prlp_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              has_res,
	input  wire prlp_pkg::result_t res,
	output logic                   can_load,
	prlp_out_if.source             results
);

	logic              valid_q;
	prlp_pkg::result_t res_q;

	assign can_load = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= has_res;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			res_q <= res;
		end
	end

	assign results.valid       = valid_q;
	assign results.range_valid = res_q.range_valid;
	assign results.range_low   = res_q.range_low;
	assign results.range_high  = res_q.range_high;
	assign results.finished    = res_q.finished;
	assign results.status      = res_q.status;

endmodule

`default_nettype wire

// ----- hw/rtl/page_range_list_parser.sv -----
// Top level of the page range list parser: input register, parser core and
// result register. Depends on prlp_pkg, prlp_in_if, prlp_out_if and the stages.
//
//   Port     Direction  Item
//   items    sink       one character of the list, or the terminator
//   results  source     a completed page range and/or the final status
//
// An item passes through the input register and then the result register,
// with the parser step in between.
// One item is accepted in every cycle while the result side keeps up.
// A stalled result holds its register and the input register; items that
// give no result still advance whenever the result register can load.
// Reset returns the parser to the start of a list with no range seen.
`default_nettype none

module page_range_list_parser (
	input  wire logic  clk,
	input  wire logic  arst_n,
	prlp_in_if.sink    items,
	prlp_out_if.source results
);

	logic              valid_s1;
	prlp_pkg::item_t   item_s1;
	logic              adv;
	logic              can_load;
	logic              has_res;
	prlp_pkg::result_t res;

	assign adv = valid_s1 && can_load;

	prlp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	prlp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.item    (item_s1),
		.has_res (has_res),
		.res     (res)
	);

	prlp_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.has_res  (has_res),
		.res      (res),
		.can_load (can_load),
		.results  (results)
	);

endmodule

`default_nettype wire

// ----- verif/page_range_list_parser_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for page_range_list_parser: directed and random page range lists are
// sent one character per item, and every result is checked against a predictor kept here.
// Depends on prlp_pkg, prlp_in_if, prlp_out_if and the parser RTL.

module page_range_list_parser_tb;

	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_ITEMS   = 1150;
	localparam int REPORT_LIMIT   = 10;

	localparam logic [prlp_pkg::CH_W-1:0] CH_NUL = 8'h00;

	typedef enum logic [4:0] {
		LP_START  = 5'b00001,
		LP_FIRST  = 5'b00010,
		LP_DASH   = 5'b00100,
		LP_SECOND = 5'b01000,
		LP_AFTER  = 5'b10000
	} list_phase_t;
	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

	logic clk;
	logic arst_n;

	prlp_in_if  char_bus();
	prlp_out_if report_bus();

	page_range_list_parser u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (char_bus),
		.results (report_bus)
	);

	list_phase_t     list_phase;
	int unsigned     page_acc;
	int unsigned     page_from;
	int              last_high;
	bit              list_failed;

	prlp_pkg::result_t             expected_reports[$];
	logic [prlp_pkg::CH_W-1:0]     list_text[$];
	prlp_pkg::result_t             seen_report;
	prlp_pkg::result_t             due_report;
	int              mismatch_count = 0;
	int              items_sent = 0;
	int              idle_cycles = 0;
	int              burst_left = 0;
	bit              gaps_on = 1'b1;
	bit              hold_request = 1'b0;

	function automatic void clear_list();
		list_phase = LP_START;
		page_acc = 0;
		page_from = 0;
		last_high = -1;
		list_failed = 1'b0;
	endfunction

	function automatic bit is_digit(logic [prlp_pkg::CH_W-1:0] c);
		return c inside {[prlp_pkg::CH_ZERO:prlp_pkg::CH_NINE]};
	endfunction

	function automatic bit is_blank(logic [prlp_pkg::CH_W-1:0] c);
		return c inside {prlp_pkg::CH_SPACE, prlp_pkg::CH_TAB, prlp_pkg::CH_LF,
			prlp_pkg::CH_CR};
	endfunction

	function automatic bit take_digit(logic [prlp_pkg::CH_W-1:0] c);
		int unsigned sum;
		sum = page_acc * 10 + (c - prlp_pkg::CH_ZERO);
		if (sum > prlp_pkg::MAX_PAGE)
			return 1'b0;
		page_acc = sum;
		return 1'b1;
	endfunction

	function automatic void put_char(logic [prlp_pkg::CH_W-1:0] c);
		list_text.insert(list_text.size(), c);
	endfunction

	task automatic parse_char(input logic [prlp_pkg::CH_W-1:0] c, input logic term);
		prlp_pkg::result_t r;
		bit                closed;
		r = '0;
		r.status = prlp_pkg::ST_OK;
		closed = 1'b0;
		if (list_failed) begin
			if (term)
				clear_list();
			return;
		end
		if (term) begin
			r.finished = 1'b1;
			case (list_phase)
				LP_FIRST: begin
					if (last_high >= int'(page_acc)) begin
						r.status = prlp_pkg::ST_UNORDER;
					end else begin
						r.range_valid = 1'b1;
						r.range_low = page_acc[prlp_pkg::PAGE_W-1:0];
						r.range_high = page_acc[prlp_pkg::PAGE_W-1:0];
					end
				end
				LP_DASH: r.status = prlp_pkg::ST_MISSING;
				LP_SECOND: begin
					if (page_from > page_acc) begin
						r.status = prlp_pkg::ST_FLIPPED;
					end else begin
						r.range_valid = 1'b1;
						r.range_low = page_from[prlp_pkg::PAGE_W-1:0];
						r.range_high = page_acc[prlp_pkg::PAGE_W-1:0];
					end
				end
				default: ;
			endcase
			clear_list();
		end else begin
			case (list_phase)
				LP_START: begin
					if (is_digit(c)) begin
						page_acc = 0;
						if (take_digit(c)) begin
							list_phase = LP_FIRST;
						end else begin
							r.finished = 1'b1;
							r.status = prlp_pkg::ST_OVERFLOW;
						end
					end else if (!is_blank(c)) begin
						r.finished = 1'b1;
						r.status = prlp_pkg::ST_MISSING;
					end
				end
				LP_FIRST: begin
					if (is_digit(c)) begin
						if (!take_digit(c)) begin
							r.finished = 1'b1;
							r.status = prlp_pkg::ST_OVERFLOW;
						end
					end else if (last_high >= int'(page_acc)) begin
						r.finished = 1'b1;
						r.status = prlp_pkg::ST_UNORDER;
					end else if (c == prlp_pkg::CH_DASH) begin
						page_from = page_acc;
						list_phase = LP_DASH;
					end else begin
						r.range_valid = 1'b1;
						r.range_low = page_acc[prlp_pkg::PAGE_W-1:0];
						r.range_high = page_acc[prlp_pkg::PAGE_W-1:0];
						closed = 1'b1;
					end
				end
				LP_DASH: begin
					if (is_digit(c)) begin
						page_acc = 0;
						if (take_digit(c)) begin
							list_phase = LP_SECOND;
						end else begin
							r.finished = 1'b1;
							r.status = prlp_pkg::ST_OVERFLOW;
						end
					end else begin
						r.finished = 1'b1;
						r.status = prlp_pkg::ST_MISSING;
					end
				end
				LP_SECOND: begin
					if (is_digit(c)) begin
						if (!take_digit(c)) begin
							r.finished = 1'b1;
							r.status = prlp_pkg::ST_OVERFLOW;
						end
					end else if (page_from > page_acc) begin
						r.finished = 1'b1;
						r.status = prlp_pkg::ST_FLIPPED;
					end else begin
						r.range_valid = 1'b1;
						r.range_low = page_from[prlp_pkg::PAGE_W-1:0];
						r.range_high = page_acc[prlp_pkg::PAGE_W-1:0];
						closed = 1'b1;
					end
				end
				default: begin
					if (c == prlp_pkg::CH_COMMA) begin
						list_phase = LP_START;
					end else if (!is_blank(c)) begin
						r.finished = 1'b1;
						r.status = prlp_pkg::ST_INVALID;
					end
				end
			endcase
			if (closed) begin
				last_high = int'(r.range_high);
				if (c == prlp_pkg::CH_COMMA) begin
					list_phase = LP_START;
				end else if (is_blank(c)) begin
					list_phase = LP_AFTER;
				end else begin
					r.finished = 1'b1;
					r.status = prlp_pkg::ST_INVALID;
				end
			end
			if (r.finished)
				list_failed = 1'b1;
		end
		if (r.range_valid || r.finished)
			expected_reports.insert(expected_reports.size(), r);
	endtask

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			char_bus.valid <= 1'b0;
			char_bus.ch <= 8'($urandom);
			char_bus.terminator <= 1'($urandom_range(0, 1));
		end
	endtask

	task automatic send_item(input logic [prlp_pkg::CH_W-1:0] c, input logic term);
		if (gaps_on && burst_left == 0) begin
			pause_sender($urandom_range(1, 6));
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		char_bus.valid <= 1'b1;
		char_bus.ch <= c;
		char_bus.terminator <= term;
		@(posedge clk);
		while (!char_bus.ready)
			@(posedge clk);
		parse_char(c, term);
		items_sent++;
	endtask

	task automatic send_list();
		foreach (list_text[i])
			send_item(list_text[i], 1'b0);
		send_item(8'($urandom), 1'b1);
	endtask

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endfunction

	task automatic send_text(string s);
		list_text.delete();
		add_text(s);
		send_list();
	endtask

	function automatic logic [prlp_pkg::CH_W-1:0] pick_blank();
		case ($urandom_range(0, 3))
			0: return prlp_pkg::CH_SPACE;
			1: return prlp_pkg::CH_TAB;
			2: return prlp_pkg::CH_LF;
			default: return prlp_pkg::CH_CR;
		endcase
	endfunction

	function automatic void add_blanks();
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 2))
				put_char(pick_blank());
	endfunction

	function automatic void add_number(int v);
		string digits;
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 2))
				put_char(prlp_pkg::CH_ZERO);
		digits = $sformatf("%0d", v);
		add_text(digits);
	endfunction

	task automatic send_random_list();
		int entries;
		int lo;
		int hi;
		int last;
		int pos;
		list_text.delete();
		gaps_on = ($urandom_range(0, 3) != 0);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 16))
				put_char(8'($urandom));
		end else begin
			entries = $urandom_range(0, 8);
			last = -1;
			for (int k = 0; k < entries; k++) begin
				case ($urandom_range(0, 15))
					0: lo = last - int'($urandom_range(0, 3));
					1: lo = int'(prlp_pkg::MAX_PAGE) - int'($urandom_range(0, 3));
					2, 3: lo = last + 1 + int'($urandom_range(0, 1500));
					default: lo = last + 1 + int'($urandom_range(0, 12));
				endcase
				if (lo < 0)
					lo = 0;
				if (lo > int'(prlp_pkg::MAX_PAGE))
					break;
				hi = lo;
				if ($urandom_range(0, 15) == 0 && lo > 0)
					hi = lo - int'($urandom_range(1, lo));
				else if ($urandom_range(0, 1) == 1)
					hi = lo + int'($urandom_range(0, 40));
				if (hi > int'(prlp_pkg::MAX_PAGE))
					hi = int'(prlp_pkg::MAX_PAGE);
				add_blanks();
				add_number(lo);
				if (hi != lo || $urandom_range(0, 3) == 0) begin
					put_char(prlp_pkg::CH_DASH);
					add_number(hi);
				end
				add_blanks();
				if (k < entries - 1 || $urandom_range(0, 2) == 0)
					put_char(prlp_pkg::CH_COMMA);
				last = hi;
			end
			if (list_text.size() != 0 && $urandom_range(0, 3) == 0) begin
				pos = $urandom_range(0, list_text.size() - 1);
				case ($urandom_range(0, 2))
					0: list_text[pos] = 8'($urandom);
					1: list_text.insert(pos, prlp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
					default: list_text.insert(pos, pick_blank());
				endcase
			end
		end
		send_list();
	endtask

	task automatic test_well_formed_lists();
		send_text("0-4351,\t");
		send_text("");
	endtask

	task automatic test_error_codes();
		send_text("4352");
		send_text("2,2");
		send_text("9-8,");
		list_text.delete();
		put_char(CH_NUL);
		send_list();
	endtask

	task automatic test_hyphen_blanks();
		send_text("1 -");
		send_text("1- ");
	endtask

	task automatic test_output_backpressure();
		gaps_on = 1'b0;
		hold_request = 1'b1;
		list_text.delete();
		for (int p = 1; p <= 40; p++) begin
			add_number(p);
			put_char(prlp_pkg::CH_COMMA);
		end
		send_list();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_lists();
		int target;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target)
			send_random_list();
		gaps_on = 1'b1;
	endtask

	task automatic note_mismatch(string what, prlp_pkg::result_t want,
		prlp_pkg::result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display({"%s: expected valid=%0b low=%0d high=%0d finished=%0b status=%0d,",
				" got valid=%0b low=%0d high=%0d finished=%0b status=%0d"},
				what, want.range_valid, want.range_low, want.range_high, want.finished,
				want.status, got.range_valid, got.range_low, got.range_high, got.finished,
				got.status);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		rx_mode_t rx_mode;
		int       hold_left;
		int       mode_left;
		int       rx_count;
		report_bus.ready = 1'b0;
		rx_mode = RX_FREE;
		hold_left = 0;
		mode_left = 0;
		rx_count = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(32, 160);
			end
			mode_left--;
			rx_count++;
			if (hold_left > 0) begin
				hold_left--;
				report_bus.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_FREE: report_bus.ready <= 1'b1;
					RX_COIN: report_bus.ready <= 1'($urandom_range(0, 1));
					RX_PATTERN: report_bus.ready <= (rx_count % 4 != 3);
					default: report_bus.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && report_bus.valid && report_bus.ready) begin
			seen_report.range_valid = report_bus.range_valid;
			seen_report.range_low = report_bus.range_low;
			seen_report.range_high = report_bus.range_high;
			seen_report.finished = report_bus.finished;
			seen_report.status = prlp_pkg::status_t'(report_bus.status);
			if (expected_reports.size() == 0) begin
				note_mismatch("result with nothing expected", '0, seen_report);
			end else begin
				due_report = expected_reports.pop_front();
				if (seen_report.range_valid !== due_report.range_valid
					|| seen_report.range_low !== due_report.range_low
					|| seen_report.range_high !== due_report.range_high
					|| seen_report.finished !== due_report.finished
					|| seen_report.status !== due_report.status)
					note_mismatch("result mismatch", due_report, seen_report);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (char_bus.valid && char_bus.ready)
			|| (report_bus.valid && report_bus.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("page_range_list_parser regression: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		char_bus.valid = 1'b0;
		char_bus.ch = '0;
		char_bus.terminator = 1'b0;
		clear_list();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_well_formed_lists();
		test_error_codes();
		test_hyphen_blanks();
		test_output_backpressure();
		test_random_lists();
		pause_sender(1);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_reports.size() == 0)
			$display("page_range_list_parser regression: pass");
		else
			$display("page_range_list_parser regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/prlp_pkg.sv
hw/rtl/prlp_in_if.sv
hw/rtl/prlp_out_if.sv
hw/rtl/prlp_in_stage.sv
hw/rtl/prlp_core.sv
hw/rtl/prlp_out_stage.sv
hw/rtl/page_range_list_parser.sv
verif/page_range_list_parser_tb.sv
